FILE: hw/rtl/lcsm_pkg.sv
// ----------------------------------------------------------------------------
// lcsm_pkg
// Shared widths, limits and types for the LSTM cell state moment pipeline.
// ----------------------------------------------------------------------------
package lcsm_pkg;

  localparam int DATA_W     = 32;
  localparam int VAR_W      = DATA_W - 1;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int MAG_W      = PROD_W - FRAC_BITS;
  localparam int ACC_W      = DATA_W + 4;
  localparam int NUM_STAGES = 9;
  localparam int S_TDATA_W  = 288;
  localparam int M_TDATA_W  = 64;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [VAR_W-1:0]         var_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [NUM_STAGES:1]      stage_en_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam var_t  VAR_MAX  = {VAR_W{1'b1}};

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_W'(1) << (DATA_W - 1);
  localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_NEG_LIM - MAG_W'(1);

  localparam acc_t ACC_DATA_MAX = ACC_W'(DATA_MAX);
  localparam acc_t ACC_DATA_MIN = ACC_W'(DATA_MIN);
  localparam acc_t ACC_ZERO     = '0;

  typedef struct packed {
    data_t pvfmfm;
    data_t pvfv;
    data_t fvpmpm;
    data_t cvimim;
    data_t ivcv;
    data_t ivcmcm;
    data_t covcov;
    data_t covimcm;
    data_t fmpm;
    data_t imcm;
    data_t cov;
  } terms_t;

endpackage

FILE: hw/rtl/lcsm_fmul.sv
// ----------------------------------------------------------------------------
// lcsm_fmul
// Three-stage fixed-point multiplier: exact product, rounding half away from
// zero, then saturation to the signed data range.
// ----------------------------------------------------------------------------
module lcsm_fmul (
  input  logic           clk,
  input  logic [2:0]     en,
  input  lcsm_pkg::data_t a,
  input  lcsm_pkg::data_t b,
  output lcsm_pkg::data_t p
);
  import lcsm_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        rsum;
  logic                     neg;
  logic [MAG_W-1:0]         mag;

  always_comb begin
    if (prod[PROD_W-1]) begin
      rsum = ROUND_HALF - prod;
    end else begin
      rsum = prod + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= a * b;
    end
    if (en[1]) begin
      neg <= prod[PROD_W-1];
      mag <= rsum[PROD_W-1:FRAC_BITS];
    end
    if (en[2]) begin
      if (neg) begin
        if (mag >= MAG_NEG_LIM) begin
          p <= DATA_MIN;
        end else begin
          p <= -$signed(mag[DATA_W-1:0]);
        end
      end else begin
        if (mag > MAG_POS_LIM) begin
          p <= DATA_MAX;
        end else begin
          p <= $signed(mag[DATA_W-1:0]);
        end
      end
    end
  end

endmodule

FILE: hw/rtl/lcsm_delay.sv
// ----------------------------------------------------------------------------
// lcsm_delay
// Register line that carries operands alongside the arithmetic stages.
// ----------------------------------------------------------------------------
module lcsm_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3
) (
  input  logic             clk,
  input  logic [DEPTH-1:0] en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  import lcsm_pkg::*;

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      line[0] <= d;
    end
    for (int j = 1; j < DEPTH; j++) begin
      if (en[j]) begin
        line[j] <= line[j-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

FILE: hw/rtl/lcsm_accum.sv
// ----------------------------------------------------------------------------
// lcsm_accum
// Three-stage adder tree for the mean and variance sums, with final clamping.
// ----------------------------------------------------------------------------
module lcsm_accum (
  input  logic             clk,
  input  logic [2:0]       en,
  input  lcsm_pkg::terms_t terms,
  output lcsm_pkg::data_t  mean,
  output lcsm_pkg::var_t   variance
);
  import lcsm_pkg::*;

  acc_t t0, t1, t2, t3, m0, cov1;
  acc_t u0, u1, m1;
  acc_t vsum;

  always_comb begin
    vsum = u0 + u1;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0   <= ACC_W'(terms.pvfmfm) + ACC_W'(terms.pvfv);
      t1   <= ACC_W'(terms.fvpmpm) + ACC_W'(terms.cvimim);
      t2   <= ACC_W'(terms.ivcv) + ACC_W'(terms.ivcmcm);
      t3   <= ACC_W'(terms.covcov) + (ACC_W'(terms.covimcm) <<< 1);
      m0   <= ACC_W'(terms.fmpm) + ACC_W'(terms.imcm);
      cov1 <= ACC_W'(terms.cov);
    end
    if (en[1]) begin
      u0 <= t0 + t1;
      u1 <= t2 + t3;
      m1 <= m0 + cov1;
    end
    if (en[2]) begin
      if (m1 > ACC_DATA_MAX) begin
        mean <= DATA_MAX;
      end else if (m1 < ACC_DATA_MIN) begin
        mean <= DATA_MIN;
      end else begin
        mean <= m1[DATA_W-1:0];
      end
      if (vsum < ACC_ZERO) begin
        variance <= '0;
      end else if (vsum > ACC_DATA_MAX) begin
        variance <= VAR_MAX;
      end else begin
        variance <= vsum[VAR_W-1:0];
      end
    end
  end

endmodule

FILE: hw/rtl/lstm_cell_state_moments_core.sv
// ----------------------------------------------------------------------------
// lstm_cell_state_moments_core
// Gaussian moment update of one LSTM cell unit per beat: new cell mean and
// variance from the gate, prior cell and covariance moments.
// It chains two 3-stage multipliers and a 3-stage adder tree; throughput is one
// beat per cycle while m_tready is high. Each stage holds its item under back
// pressure and empty stages fill, so s_tready drops only when all 9 are occupied.
// Reset (rst, synchronous) clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module lstm_cell_state_moments_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // forget_mean, forget_var, ingate_mean, ingate_var, candidate_mean,
  // candidate_var, prior_cell_mean, prior_cell_var, gate_covariance, zero fill
  input  logic [lcsm_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // cell_mean, cell_var, zero fill
  output logic [lcsm_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast
);
  import lcsm_pkg::*;

  stage_en_t vld;
  stage_en_t en;

  data_t fm, im, cm, pm, cov;
  data_t fv, iv, cv, pv;

  data_t fmpm, imcm, pvfm, pvfv, fvpm, cvim, ivcv, ivcm, covcov, covim;
  data_t fm3, pm3, im3, cm3, cov3;
  data_t pvfmfm, fvpmpm, cvimim, ivcmcm, covimcm;
  data_t pvfv6, ivcv6, covcov6, fmpm6, imcm6, cov6;
  terms_t terms;
  data_t  mean;
  var_t   variance;

  assign fm  = s_tdata[31:0];
  assign fv  = $signed({1'b0, s_tdata[62:32]});
  assign im  = s_tdata[94:63];
  assign iv  = $signed({1'b0, s_tdata[125:95]});
  assign cm  = s_tdata[157:126];
  assign cv  = $signed({1'b0, s_tdata[188:158]});
  assign pm  = s_tdata[220:189];
  assign pv  = $signed({1'b0, s_tdata[251:221]});
  assign cov = s_tdata[283:252];

  always_comb begin
    en[NUM_STAGES] = !vld[NUM_STAGES] || m_tready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = en[1];

  lcsm_fmul u_fmpm   (.clk, .en(en[3:1]), .a(fm),  .b(pm),  .p(fmpm));
  lcsm_fmul u_imcm   (.clk, .en(en[3:1]), .a(im),  .b(cm),  .p(imcm));
  lcsm_fmul u_pvfm   (.clk, .en(en[3:1]), .a(pv),  .b(fm),  .p(pvfm));
  lcsm_fmul u_pvfv   (.clk, .en(en[3:1]), .a(pv),  .b(fv),  .p(pvfv));
  lcsm_fmul u_fvpm   (.clk, .en(en[3:1]), .a(fv),  .b(pm),  .p(fvpm));
  lcsm_fmul u_cvim   (.clk, .en(en[3:1]), .a(cv),  .b(im),  .p(cvim));
  lcsm_fmul u_ivcv   (.clk, .en(en[3:1]), .a(iv),  .b(cv),  .p(ivcv));
  lcsm_fmul u_ivcm   (.clk, .en(en[3:1]), .a(iv),  .b(cm),  .p(ivcm));
  lcsm_fmul u_covcov (.clk, .en(en[3:1]), .a(cov), .b(cov), .p(covcov));
  lcsm_fmul u_covim  (.clk, .en(en[3:1]), .a(cov), .b(im),  .p(covim));

  lcsm_delay #(.WIDTH(5 * DATA_W), .DEPTH(3)) u_opnd_dly (
    .clk,
    .en(en[3:1]),
    .d({fm, pm, im, cm, cov}),
    .q({fm3, pm3, im3, cm3, cov3})
  );

  lcsm_fmul u_pvfmfm  (.clk, .en(en[6:4]), .a(pvfm),  .b(fm3), .p(pvfmfm));
  lcsm_fmul u_fvpmpm  (.clk, .en(en[6:4]), .a(fvpm),  .b(pm3), .p(fvpmpm));
  lcsm_fmul u_cvimim  (.clk, .en(en[6:4]), .a(cvim),  .b(im3), .p(cvimim));
  lcsm_fmul u_ivcmcm  (.clk, .en(en[6:4]), .a(ivcm),  .b(cm3), .p(ivcmcm));
  lcsm_fmul u_covimcm (.clk, .en(en[6:4]), .a(covim), .b(cm3), .p(covimcm));

  lcsm_delay #(.WIDTH(6 * DATA_W), .DEPTH(3)) u_term_dly (
    .clk,
    .en(en[6:4]),
    .d({pvfv, ivcv, covcov, fmpm, imcm, cov3}),
    .q({pvfv6, ivcv6, covcov6, fmpm6, imcm6, cov6})
  );

  lcsm_delay #(.WIDTH(1), .DEPTH(NUM_STAGES)) u_last_dly (
    .clk,
    .en(en),
    .d(s_tlast),
    .q(m_tlast)
  );

  always_comb begin
    terms.pvfmfm  = pvfmfm;
    terms.pvfv    = pvfv6;
    terms.fvpmpm  = fvpmpm;
    terms.cvimim  = cvimim;
    terms.ivcv    = ivcv6;
    terms.ivcmcm  = ivcmcm;
    terms.covcov  = covcov6;
    terms.covimcm = covimcm;
    terms.fmpm    = fmpm6;
    terms.imcm    = imcm6;
    terms.cov     = cov6;
  end

  lcsm_accum u_accum (
    .clk,
    .en(en[9:7]),
    .terms(terms),
    .mean(mean),
    .variance(variance)
  );

  assign m_tvalid = vld[NUM_STAGES];
  assign m_tdata  = {1'b0, variance, mean};

`ifndef NO_ASSERTIONS
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&vld))
    else $error("input stalled while a pipeline stage is empty");

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[1])
    else $error("accepted beat did not enter the first stage");

  a_drain_empties_output: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !vld[NUM_STAGES-1]) |=> !m_tvalid)
    else $error("output beat repeated after it was taken");
`endif

endmodule
